/* sv/ppm_fg_pkg.sv */
// ppm_fg_pkg: constants, microcode types and the control store of the ppm frame generator
package ppm_fg_pkg;

  localparam int CHANNELS = 8;
  localparam int ADDR_W   = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int CH_CNT_W = $clog2(CHANNELS + 1);
  // sum of all widths plus all gaps, each at most 16 bits
  localparam int ACC_W    = 18 + $clog2(CHANNELS);
  localparam int STEP_W   = 5;
  localparam int WIDTH_W  = 16;
  localparam int PADDR_W  = 5;
  localparam int PDATA_W  = 32;

  localparam logic [WIDTH_W-1:0] WIDTH_MAX = 16'hFFFF;

  // configuration register indexes
  localparam logic [2:0] REG_GAP      = 3'd0;
  localparam logic [2:0] REG_FRAME    = 3'd1;
  localparam logic [2:0] REG_SYNC_MIN = 3'd2;
  localparam logic [2:0] REG_OUT_MIN  = 3'd3;
  localparam logic [2:0] REG_OUT_MAX  = 3'd4;
  localparam logic [2:0] REG_CENTER   = 3'd5;

  typedef enum logic [2:0] {
    OP_TICK   = 3'd0,
    OP_SET    = 3'd1,
    OP_COMMIT = 3'd2,
    OP_READ   = 3'd3,
    OP_FILL   = 3'd4,
    OP_START  = 3'd5,
    OP_STOP   = 3'd6
  } op_t;

  typedef enum logic [4:0] {
    U_NOP,
    U_DONE,
    U_TICK,
    U_ADDR_ZERO,
    U_ADDR_NEXT,
    U_LOAD_IDX,
    U_PIN_LOW,
    U_SUM_INIT,
    U_SUM_ADD,
    U_SYNC,
    U_GAP,
    U_BEGIN,
    U_SET_WR,
    U_COPY,
    U_RD,
    U_RD_CENTER,
    U_FILL,
    U_STOP
  } uop_t;

  typedef enum logic [3:0] {
    C_NEXT,
    C_ALWAYS,
    C_INACTIVE,
    C_ACTIVE,
    C_BELOW_LEN,
    C_PH_PULSE,
    C_PH_GAP,
    C_NOT_LAST_CH,
    C_IDX_OUT,
    C_ADDR_NOT_LAST
  } cond_t;

  typedef struct packed {
    uop_t              uop;
    cond_t             cond;
    logic [STEP_W-1:0] target;
  } ctrl_word_t;

  // program entry points and jump targets
  localparam logic [STEP_W-1:0] S_DONE       = 5'd0;
  localparam logic [STEP_W-1:0] S_TICK       = 5'd1;
  localparam logic [STEP_W-1:0] S_PULSE_END  = 5'd6;
  localparam logic [STEP_W-1:0] S_SUM_LOOP   = 5'd8;
  localparam logic [STEP_W-1:0] S_GAP_END    = 5'd10;
  localparam logic [STEP_W-1:0] S_BEGIN      = 5'd11;
  localparam logic [STEP_W-1:0] S_GAP_SET    = 5'd12;
  localparam logic [STEP_W-1:0] S_SET        = 5'd13;
  localparam logic [STEP_W-1:0] S_COMMIT     = 5'd16;
  localparam logic [STEP_W-1:0] S_COPY_LOOP  = 5'd17;
  localparam logic [STEP_W-1:0] S_READ       = 5'd19;
  localparam logic [STEP_W-1:0] S_RD_CENTER  = 5'd22;
  localparam logic [STEP_W-1:0] S_FILL       = 5'd23;
  localparam logic [STEP_W-1:0] S_FILL_LOOP  = 5'd24;
  localparam logic [STEP_W-1:0] S_START      = 5'd26;
  localparam logic [STEP_W-1:0] S_START_LOOP = 5'd28;
  localparam logic [STEP_W-1:0] S_STOP       = 5'd31;

  function automatic logic [STEP_W-1:0] entry_step(input logic [2:0] op);
    logic [STEP_W-1:0] s;
    case (op)
      OP_TICK:   s = S_TICK;
      OP_SET:    s = S_SET;
      OP_COMMIT: s = S_COMMIT;
      OP_READ:   s = S_READ;
      OP_FILL:   s = S_FILL;
      OP_START:  s = S_START;
      OP_STOP:   s = S_STOP;
      default:   s = S_DONE;
    endcase
    return s;
  endfunction

  function automatic ctrl_word_t ucode(input logic [STEP_W-1:0] step);
    ctrl_word_t w;
    unique case (step)
      5'd0:    w = '{U_DONE,      C_NEXT,          S_DONE};
      // tick
      5'd1:    w = '{U_TICK,      C_INACTIVE,      S_DONE};
      5'd2:    w = '{U_NOP,       C_BELOW_LEN,     S_DONE};
      5'd3:    w = '{U_NOP,       C_PH_PULSE,      S_PULSE_END};
      5'd4:    w = '{U_NOP,       C_PH_GAP,        S_GAP_END};
      5'd5:    w = '{U_ADDR_ZERO, C_ALWAYS,        S_BEGIN};
      5'd6:    w = '{U_PIN_LOW,   C_NOT_LAST_CH,   S_GAP_SET};
      5'd7:    w = '{U_SUM_INIT,  C_NEXT,          S_DONE};
      5'd8:    w = '{U_SUM_ADD,   C_ADDR_NOT_LAST, S_SUM_LOOP};
      5'd9:    w = '{U_SYNC,      C_ALWAYS,        S_DONE};
      5'd10:   w = '{U_ADDR_NEXT, C_NEXT,          S_DONE};
      5'd11:   w = '{U_BEGIN,     C_ALWAYS,        S_DONE};
      5'd12:   w = '{U_GAP,       C_ALWAYS,        S_DONE};
      // set channel
      5'd13:   w = '{U_NOP,       C_IDX_OUT,       S_DONE};
      5'd14:   w = '{U_LOAD_IDX,  C_NEXT,          S_DONE};
      5'd15:   w = '{U_SET_WR,    C_ALWAYS,        S_DONE};
      // commit
      5'd16:   w = '{U_ADDR_ZERO, C_NEXT,          S_DONE};
      5'd17:   w = '{U_COPY,      C_ADDR_NOT_LAST, S_COPY_LOOP};
      5'd18:   w = '{U_DONE,      C_NEXT,          S_DONE};
      // read channel
      5'd19:   w = '{U_NOP,       C_IDX_OUT,       S_RD_CENTER};
      5'd20:   w = '{U_LOAD_IDX,  C_NEXT,          S_DONE};
      5'd21:   w = '{U_RD,        C_ALWAYS,        S_DONE};
      5'd22:   w = '{U_RD_CENTER, C_ALWAYS,        S_DONE};
      // fill center
      5'd23:   w = '{U_ADDR_ZERO, C_NEXT,          S_DONE};
      5'd24:   w = '{U_FILL,      C_ADDR_NOT_LAST, S_FILL_LOOP};
      5'd25:   w = '{U_DONE,      C_NEXT,          S_DONE};
      // start
      5'd26:   w = '{U_NOP,       C_ACTIVE,        S_DONE};
      5'd27:   w = '{U_ADDR_ZERO, C_NEXT,          S_DONE};
      5'd28:   w = '{U_FILL,      C_ADDR_NOT_LAST, S_START_LOOP};
      5'd29:   w = '{U_ADDR_ZERO, C_NEXT,          S_DONE};
      5'd30:   w = '{U_BEGIN,     C_ALWAYS,        S_DONE};
      // stop
      5'd31:   w = '{U_STOP,      C_ALWAYS,        S_DONE};
      default: w = '{U_DONE,      C_NEXT,          S_DONE};
    endcase
    return w;
  endfunction

endpackage

/* sv/ppm_frame_generator.sv */
// ppm_frame_generator: microcoded ppm pulse train generator with an apb register port
//
// in channel (in_valid/in_ready): one beat is a tick of one microsecond or a buffer access,
// selected by operation (tick, set channel, commit, read channel, fill center, start, stop).
// out channel (out_valid/out_ready): exactly one beat per input beat, carrying the pin
// level and running flag after that item and read_value (zero except for a read).
// apb port: six 16-bit timing registers at byte addresses 0, 4, .. 20, written in the
// access phase; pready is tied high and reads return the register value.
// one item is worked on at a time. a step counter walks a control store, one step a cycle
// unless the final step holds for the output register; a tick that ends the last channel's
// pulse sums the sync time one channel a cycle through the single adder. in_ready rises
// again in the same cycle as the result is loaded.
// the result sits in an output register; a new item is accepted while it waits, and only
// the final step of that item holds until out_ready frees the register.
// reset (synchronous) loads the default timings, zeroes both buffers, stops the train and
// drives the pin low.
module ppm_frame_generator
  import ppm_fg_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  // input beats
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic [2:0]           operation,
  input  logic [7:0]           channel_index,
  input  logic [WIDTH_W-1:0]   pulse_value,
  // result beats
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic                 pin_level,
  output logic [WIDTH_W-1:0]   read_value,
  output logic                 running,
  // register port
  input  logic                 psel,
  input  logic                 penable,
  input  logic                 pwrite,
  input  logic [PADDR_W-1:0]   paddr,
  input  logic [PDATA_W-1:0]   pwdata,
  output logic [PDATA_W-1:0]   prdata,
  output logic                 pready
);

  typedef enum logic [1:0] {
    PH_PULSE = 2'd0,
    PH_GAP   = 2'd1,
    PH_SYNC  = 2'd2
  } phase_t;

  // timing registers
  logic [WIDTH_W-1:0] gap_us, frame_us, sync_min_us, out_min_us, out_max_us, center_us;

  // buffers, all accessed at the one address addr
  logic [WIDTH_W-1:0] staging [CHANNELS];
  logic [WIDTH_W-1:0] frame   [CHANNELS];

  // sequencer and datapath
  logic               busy;
  logic [STEP_W-1:0]  step;
  logic [ADDR_W-1:0]  addr;
  logic [ACC_W-1:0]   acc;
  logic [7:0]         idx;
  logic [WIDTH_W-1:0] val;
  logic [WIDTH_W-1:0] rd;

  // generator state
  logic [ADDR_W-1:0]  current_channel;
  phase_t             phase;
  logic [WIDTH_W-1:0] elapsed;
  logic [WIDTH_W-1:0] phase_length;
  logic               pin;
  logic               active;

  ctrl_word_t         cw;
  logic               jump;
  logic               in_beat;
  logic               out_free;
  logic [ADDR_W-1:0]  addr_inc;
  logic [ADDR_W-1:0]  channel_inc;
  logic [WIDTH_W-1:0] clamped;
  logic [WIDTH_W-1:0] sync_len;
  logic [ACC_W-1:0]   frame_ext;
  logic [ACC_W-1:0]   sync_diff;
  logic               cfg_write;

  assign in_ready  = !busy;
  assign in_beat   = in_valid && in_ready;
  assign out_free  = !out_valid || out_ready;
  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready;

  assign cw = ucode(step);

  always_comb begin
    case (cw.cond)
      C_NEXT:          jump = 1'b0;
      C_ALWAYS:        jump = 1'b1;
      C_INACTIVE:      jump = !active;
      C_ACTIVE:        jump = active;
      C_BELOW_LEN:     jump = elapsed < phase_length;
      C_PH_PULSE:      jump = phase == PH_PULSE;
      C_PH_GAP:        jump = phase == PH_GAP;
      C_NOT_LAST_CH:   jump = current_channel != ADDR_W'(CHANNELS - 1);
      C_IDX_OUT:       jump = idx >= 8'(CHANNELS);
      C_ADDR_NOT_LAST: jump = addr != ADDR_W'(CHANNELS - 1);
      default:         jump = 1'b0;
    endcase
  end

  assign addr_inc    = (addr == ADDR_W'(CHANNELS - 1)) ? '0 : addr + 1'b1;
  assign channel_inc = (current_channel == ADDR_W'(CHANNELS - 1)) ? '0
                     : current_channel + 1'b1;

  // minimum first, then maximum, so the maximum wins when the limits cross
  always_comb begin
    clamped = val;
    if (clamped < out_min_us) clamped = out_min_us;
    if (clamped > out_max_us) clamped = out_max_us;
  end

  assign frame_ext = ACC_W'(frame_us);
  assign sync_diff = frame_ext - acc;

  always_comb begin
    if (acc >= frame_ext) begin
      sync_len = sync_min_us;
    end else if (sync_diff < ACC_W'(sync_min_us)) begin
      sync_len = sync_min_us;
    end else begin
      sync_len = sync_diff[WIDTH_W-1:0];
    end
  end

  always_comb begin
    case (paddr[4:2])
      REG_GAP:      prdata = PDATA_W'(gap_us);
      REG_FRAME:    prdata = PDATA_W'(frame_us);
      REG_SYNC_MIN: prdata = PDATA_W'(sync_min_us);
      REG_OUT_MIN:  prdata = PDATA_W'(out_min_us);
      REG_OUT_MAX:  prdata = PDATA_W'(out_max_us);
      REG_CENTER:   prdata = PDATA_W'(center_us);
      default:      prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      gap_us          <= 16'd300;
      frame_us        <= 16'd22500;
      sync_min_us     <= 16'd3000;
      out_min_us      <= 16'd800;
      out_max_us      <= 16'd2200;
      center_us       <= 16'd1500;
      for (int i = 0; i < CHANNELS; i++) begin
        staging[i] <= '0;
        frame[i]   <= '0;
      end
      busy            <= 1'b0;
      step            <= S_DONE;
      addr            <= '0;
      current_channel <= '0;
      phase           <= PH_PULSE;
      elapsed         <= '0;
      phase_length    <= '0;
      pin             <= 1'b0;
      active          <= 1'b0;
      out_valid       <= 1'b0;
    end else begin
      if (cfg_write) begin
        case (paddr[4:2])
          REG_GAP:      gap_us      <= pwdata[WIDTH_W-1:0];
          REG_FRAME:    frame_us    <= pwdata[WIDTH_W-1:0];
          REG_SYNC_MIN: sync_min_us <= pwdata[WIDTH_W-1:0];
          REG_OUT_MIN:  out_min_us  <= pwdata[WIDTH_W-1:0];
          REG_OUT_MAX:  out_max_us  <= pwdata[WIDTH_W-1:0];
          REG_CENTER:   center_us   <= pwdata[WIDTH_W-1:0];
          default:      ;
        endcase
      end

      // a finishing item reloads the register in the same cycle
      if (out_valid && out_ready && !(busy && cw.uop == U_DONE)) out_valid <= 1'b0;

      if (in_beat) begin
        busy <= 1'b1;
        step <= entry_step(operation);
        idx  <= channel_index;
        val  <= pulse_value;
        rd   <= '0;
      end else if (busy) begin
        if (cw.uop != U_DONE) step <= jump ? cw.target : step + 1'b1;

        unique case (cw.uop)
          U_NOP: ;
          U_DONE: begin
            // hold here while the previous result is still waiting
            if (out_free) begin
              busy       <= 1'b0;
              out_valid  <= 1'b1;
              pin_level  <= pin;
              read_value <= rd;
              running    <= active;
            end
          end
          U_TICK: begin
            if (active && elapsed != WIDTH_MAX) elapsed <= elapsed + 1'b1;
          end
          U_ADDR_ZERO: addr <= '0;
          U_ADDR_NEXT: addr <= channel_inc;
          U_LOAD_IDX:  addr <= idx[ADDR_W-1:0];
          U_PIN_LOW: begin
            pin     <= 1'b0;
            elapsed <= '0;
          end
          U_SUM_INIT: begin
            acc  <= ACC_W'(CHANNELS - 1) * ACC_W'(gap_us);
            addr <= '0;
          end
          U_SUM_ADD: begin
            acc  <= acc + ACC_W'(frame[addr]);
            addr <= addr_inc;
          end
          U_SYNC: begin
            phase        <= PH_SYNC;
            phase_length <= sync_len;
          end
          U_GAP: begin
            phase        <= PH_GAP;
            phase_length <= gap_us;
          end
          U_BEGIN: begin
            current_channel <= addr;
            phase           <= PH_PULSE;
            pin             <= 1'b1;
            phase_length    <= frame[addr];
            elapsed         <= '0;
            active          <= 1'b1;
          end
          U_SET_WR: staging[addr] <= clamped;
          U_COPY: begin
            frame[addr] <= staging[addr];
            addr        <= addr_inc;
          end
          U_RD:        rd <= staging[addr];
          U_RD_CENTER: rd <= center_us;
          U_FILL: begin
            staging[addr] <= center_us;
            frame[addr]   <= center_us;
            addr          <= addr_inc;
          end
          U_STOP: begin
            pin    <= 1'b0;
            active <= 1'b0;
          end
          default: ;
        endcase
      end
    end
  end

`ifndef SYNTHESIS
  a_pin_needs_run: assert property (@(posedge clk) disable iff (rst) pin |-> active)
    else $error("pin high while the train is stopped");

  a_addr_range: assert property (@(posedge clk) disable iff (rst)
    CH_CNT_W'(addr) < CH_CNT_W'(CHANNELS))
    else $error("buffer address beyond the channel count");

  a_channel_range: assert property (@(posedge clk) disable iff (rst)
    CH_CNT_W'(current_channel) < CH_CNT_W'(CHANNELS))
    else $error("current channel beyond the channel count");

  a_accept_busy: assert property (@(posedge clk) disable iff (rst) in_beat |=> busy)
    else $error("sequencer idle after accepting a beat");

  a_done_stall: assert property (@(posedge clk) disable iff (rst)
    (busy && cw.uop == U_DONE && out_valid && !out_ready) |=> (busy && $stable(step)))
    else $error("result finished while the output register was full");
`endif

endmodule

/* test/tb_top.sv */
// tb_top: self-checking bench for the ppm frame generator, random beats against a predictor
module tb_top
  import ppm_fg_pkg::*;
();

  localparam int CYCLE_LIMIT  = 500000;
  localparam int CHOKE_CYCLES = 400;
  localparam int DRAIN_CYCLES = 30;
  localparam logic [2:0] OP_UNUSED = 3'd7;

  typedef enum bit [1:0] {
    SEG_PULSE,
    SEG_GAP,
    SEG_SYNC
  } seg_t;

  typedef struct packed {
    logic        pin_level;
    logic [15:0] read_value;
    logic        running;
  } pin_beat_t;

  // tracks the pulse train and queues the beat each accepted item should produce
  class ppm_scoreboard_t;
    bit [15:0]   gap_len, frame_len, sync_floor, clamp_lo, clamp_hi, centre;
    bit [15:0]   staged [CHANNELS];
    bit [15:0]   live   [CHANNELS];
    int unsigned chan;
    seg_t        seg;
    bit [15:0]   elapsed, seg_len;
    bit          pin, on;
    pin_beat_t   due[$];
    int          mismatches;

    function new();
      gap_len    = 300;
      frame_len  = 22500;
      sync_floor = 3000;
      clamp_lo   = 800;
      clamp_hi   = 2200;
      centre     = 1500;
      foreach (staged[i]) begin
        staged[i] = 0;
        live[i]   = 0;
      end
      chan       = 0;
      seg        = SEG_PULSE;
      elapsed    = 0;
      seg_len    = 0;
      pin        = 0;
      on         = 0;
      mismatches = 0;
    endfunction

    function void flag(string what);
      mismatches++;
      if (mismatches <= 10) $display("mismatch: %s", what);
    endfunction

    function void set_reg(logic [2:0] idx, bit [15:0] v);
      case (idx)
        REG_GAP:      gap_len    = v;
        REG_FRAME:    frame_len  = v;
        REG_SYNC_MIN: sync_floor = v;
        REG_OUT_MIN:  clamp_lo   = v;
        REG_OUT_MAX:  clamp_hi   = v;
        REG_CENTER:   centre     = v;
        default: ;
      endcase
    endfunction

    function bit [15:0] sync_time();
      int unsigned used;
      used = 0;
      foreach (live[i]) used += live[i];
      used += (CHANNELS - 1) * gap_len;
      if (used >= frame_len || frame_len - used < sync_floor) return sync_floor;
      return 16'(frame_len - used);
    endfunction

    function void start_channel(int unsigned c);
      chan    = (c >= CHANNELS) ? 0 : c;
      seg     = SEG_PULSE;
      pin     = 1;
      seg_len = live[chan];
      elapsed = 0;
    endfunction

    function void end_segment();
      case (seg)
        SEG_PULSE: begin
          pin     = 0;
          elapsed = 0;
          if (chan < CHANNELS - 1) begin
            seg     = SEG_GAP;
            seg_len = gap_len;
          end else begin
            seg     = SEG_SYNC;
            seg_len = sync_time();
          end
        end
        SEG_GAP: start_channel(chan + 1);
        default: start_channel(0);
      endcase
    endfunction

    function void note_beat(logic [2:0] op, logic [7:0] idx, logic [15:0] v);
      pin_beat_t b;
      bit [15:0] w;
      b.read_value = 0;
      case (op)
        OP_TICK: begin
          if (on) begin
            if (elapsed != 16'hFFFF) elapsed++;
            if (elapsed >= seg_len) end_segment();
          end
        end
        OP_SET: begin
          if (idx < CHANNELS) begin
            w = v;
            if (w < clamp_lo) w = clamp_lo;
            if (w > clamp_hi) w = clamp_hi;
            staged[idx] = w;
          end
        end
        OP_COMMIT: live = staged;
        OP_READ: b.read_value = (idx < CHANNELS) ? staged[idx] : centre;
        OP_FILL: begin
          foreach (staged[i]) staged[i] = centre;
          live = staged;
        end
        OP_START: begin
          if (!on) begin
            foreach (staged[i]) staged[i] = centre;
            live = staged;
            start_channel(0);
            on = 1;
          end
        end
        OP_STOP: begin
          if (on) begin
            pin = 0;
            on  = 0;
          end
        end
        default: ;
      endcase
      b.pin_level = pin;
      b.running   = on;
      due.push_back(b);
    endfunction

    function void check_beat(pin_beat_t got);
      pin_beat_t want;
      if (due.size() == 0) begin
        flag($sformatf("unexpected beat pin=%b read=%0d run=%b",
                       got.pin_level, got.read_value, got.running));
        return;
      end
      want = due.pop_front();
      if (got.pin_level !== want.pin_level || got.read_value !== want.read_value ||
          got.running !== want.running)
        flag($sformatf("pin %b/%b read %0d/%0d run %b/%b (expected/actual)",
                       want.pin_level, got.pin_level, want.read_value, got.read_value,
                       want.running, got.running));
    endfunction
  endclass

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 in_valid = 1'b0;
  logic                 in_ready;
  logic [2:0]           operation = OP_TICK;
  logic [7:0]           channel_index = '0;
  logic [WIDTH_W-1:0]   pulse_value = '0;
  logic                 out_valid;
  logic                 out_ready = 1'b0;
  logic                 pin_level;
  logic [WIDTH_W-1:0]   read_value;
  logic                 running;
  logic                 psel = 1'b0;
  logic                 penable = 1'b0;
  logic                 pwrite = 1'b0;
  logic [PADDR_W-1:0]   paddr = '0;
  logic [PDATA_W-1:0]   pwdata = '0;
  logic [PDATA_W-1:0]   prdata;
  logic                 pready;

  bit              steady = 1'b0;
  bit              choke_req = 1'b0;
  bit [15:0]       cur_lo = 800;
  bit [15:0]       cur_hi = 2200;
  int unsigned     cycles = 0;
  ppm_scoreboard_t sb;

  ppm_frame_generator uut (.*);

  initial begin
    forever #1 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (!rst) begin
      if (in_valid && in_ready) sb.note_beat(operation, channel_index, pulse_value);
      if (out_valid && out_ready)
        sb.check_beat(pin_beat_t'({pin_level, read_value, running}));
    end
  end

  // result side: random stalls, one long hold-off on request
  initial begin
    int n;
    @(posedge clk);
    forever begin
      if (choke_req) begin
        choke_req = 1'b0;
        out_ready <= 1'b0;
        n = CHOKE_CYCLES;
      end else if (!steady && $urandom_range(0, 3) == 0) begin
        out_ready <= 1'b0;
        n = $urandom_range(1, 19);
      end else begin
        out_ready <= 1'b1;
        n = steady ? 1 : $urandom_range(1, 40);
      end
      repeat (n) @(posedge clk);
    end
  end

  task automatic send(input logic [2:0] op, input logic [7:0] idx, input logic [15:0] v);
    if (!steady && $urandom_range(0, 5) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 19)) @(posedge clk);
    end
    in_valid      <= 1'b1;
    operation     <= op;
    channel_index <= idx;
    pulse_value   <= v;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    @(posedge clk);
    while (sb.due.size() != 0) @(posedge clk);
  endtask

  task automatic apb_write(input logic [2:0] idx, input bit [15:0] v);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= PDATA_W'(v);
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    // read it straight back
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    if (prdata !== PDATA_W'(v))
      sb.flag($sformatf("register %0d read %0d, written %0d", idx, prdata, v));
    psel    <= 1'b0;
    penable <= 1'b0;
    sb.set_reg(idx, v);
    @(posedge clk);
  endtask

  function automatic logic [15:0] width_pick();
    int span;
    span = ((cur_lo > cur_hi) ? cur_lo : cur_hi) + 4;
    if (span > 65535) span = 65535;
    return ($urandom_range(0, 3) == 0) ? 16'($urandom()) : 16'($urandom_range(0, span));
  endfunction

  task automatic random_items(input int n);
    int k;
    int r;
    logic [7:0] idx;
    k = 0;
    while (k < n) begin
      r   = $urandom_range(0, 199);
      idx = ($urandom_range(0, 6) == 0) ? 8'($urandom()) :
                                          8'($urandom_range(0, CHANNELS - 1));
      if (r < 6) begin
        // a whole frame of widths, then commit
        for (int c = 0; c < CHANNELS; c++) send(OP_SET, 8'(c), width_pick());
        send(OP_COMMIT, 8'($urandom()), 16'($urandom()));
        k += CHANNELS + 1;
      end else begin
        if (r < 140)      send(OP_TICK, 8'($urandom()), 16'($urandom()));
        else if (r < 158) send(OP_SET, idx, width_pick());
        else if (r < 168) send(OP_READ, idx, 16'($urandom()));
        else if (r < 176) send(OP_COMMIT, idx, 16'($urandom()));
        else if (r < 179) send(OP_FILL, idx, 16'($urandom()));
        else if (r < 186) send(OP_START, idx, 16'($urandom()));
        else if (r < 188) send(OP_STOP, idx, 16'($urandom()));
        else if (r < 192) send(OP_UNUSED, idx, 16'($urandom()));
        else              send(OP_TICK, idx, 16'($urandom()));
        k++;
      end
    end
  endtask

  task automatic set_timing(input bit [15:0] gap, input bit [15:0] frame,
                            input bit [15:0] smin, input bit [15:0] lo,
                            input bit [15:0] hi, input bit [15:0] ctr);
    wait_drained();
    apb_write(REG_GAP, gap);
    apb_write(REG_FRAME, frame);
    apb_write(REG_SYNC_MIN, smin);
    apb_write(REG_OUT_MIN, lo);
    apb_write(REG_OUT_MAX, hi);
    apb_write(REG_CENTER, ctr);
    cur_lo = lo;
    cur_hi = hi;
    // restart so the new centre is picked up
    send(OP_STOP, 8'($urandom()), 16'($urandom()));
    send(OP_START, 8'($urandom()), 16'($urandom()));
  endtask

  initial begin
    sb = new();
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // reset timings
    send(OP_READ, 8'd0, 16'd0);
    send(OP_READ, 8'(CHANNELS), 16'd0);
    send(OP_READ, 8'hFF, 16'hFFFF);
    send(OP_SET, 8'd0, 16'd0);
    send(OP_SET, 8'(CHANNELS - 1), 16'hFFFF);
    send(OP_SET, 8'(CHANNELS), 16'd1000);
    send(OP_SET, 8'hFF, 16'd1000);
    send(OP_SET, 8'd3, 16'd1234);
    send(OP_READ, 8'd0, 16'd0);
    send(OP_READ, 8'(CHANNELS - 1), 16'd0);
    send(OP_READ, 8'd3, 16'd0);
    send(OP_COMMIT, 8'd0, 16'd0);
    send(OP_TICK, 8'd0, 16'd0);
    send(OP_STOP, 8'd0, 16'd0);
    send(OP_UNUSED, 8'h5A, 16'hA5A5);
    send(OP_FILL, 8'd0, 16'd0);
    send(OP_READ, 8'd3, 16'd0);
    send(OP_START, 8'd0, 16'd0);
    send(OP_START, 8'd0, 16'd0);
    repeat (3) send(OP_TICK, 8'd0, 16'd0);
    send(OP_SET, 8'd2, 16'd900);
    send(OP_COMMIT, 8'd0, 16'd0);
    send(OP_STOP, 8'd0, 16'd0);
    send(OP_TICK, 8'd0, 16'd0);
    send(OP_READ, 8'd9, 16'd0);

    // short frames, with the result side choked halfway
    set_timing(16'd1, 16'd40, 16'd3, 16'd1, 16'd5, 16'd2);
    random_items(150);
    choke_req = 1'b1;
    random_items(150);

    set_timing(16'd1, 16'd1, 16'd1, 16'd1, 16'd1, 16'd1);
    random_items(150);

    // lower clamp above the upper one
    set_timing(16'd2, 16'd90, 16'd5, 16'd9, 16'd3, 16'd4);
    random_items(200);

    set_timing(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
    random_items(40);

    for (int p = 0; p < 3; p++) begin
      set_timing(16'($urandom_range(1, 4)), 16'($urandom_range(1, 100)),
                 16'($urandom_range(1, 12)), 16'($urandom_range(1, 6)),
                 16'($urandom_range(1, 10)), 16'($urandom_range(1, 8)));
      if (p == 2) steady = 1'b1;
      random_items(245);
    end

    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (sb.mismatches == 0 && sb.due.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
